/* rtl/dpfm_pkg.sv */
// shared constants, codes and types for the demand page fault mapper
// used by every module under rtl/ but dpfm_ram, and by the testbench; no dependencies
package dpfm_pkg;

    // default sizing, handed to the top level parameters
    localparam int DEF_WINDOW_BLOCKS = 2;
    localparam int DEF_POOL_FRAMES   = 512;
    localparam int ENTRIES_PER_TABLE = 512;

    // address geometry
    localparam int VA_W        = 39;
    localparam int PA_W        = 40;
    localparam int PAGE_SHIFT  = 12;
    localparam int BLOCK_SHIFT = 21;
    localparam int VPN_W       = VA_W - PAGE_SHIFT;
    localparam int PPN_W       = PA_W - PAGE_SHIFT;

    // result fields
    localparam int STATUS_W = 2;
    localparam int DESC_W   = 55;
    localparam int CNT_W    = 32;

    // descriptor bits around the output address: uxn, pxn above it,
    // af, inner shareable, attr index 1 and page type below it
    localparam logic [DESC_W-PA_W-1:0]  DESC_UPPER = 15'b110_0000_0000_0000;
    localparam logic [PAGE_SHIFT-1:0]   DESC_LOWER = 12'h707;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_MAPPED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOMEM   = 2'd3;

    // apb register map, 8-byte spacing, selected by paddr[3]
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam logic REG_WINDOW_BASE = 1'b0;
    localparam logic REG_POOL_BASE   = 1'b1;
    localparam logic [VA_W-1:0] WINDOW_BASE_RST = 39'h00_8000_0000;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_back_state;

endpackage

/* rtl/demand_page_fault_mapper_core.sv */
// in-window item: queue slot, entry read in ST_IDLE, decide and write back in ST_LOOK on
// the one memory port, then the result register, with no new item taken in between;
// outside item: ST_IDLE to result register, one per cycle while the result is not stalled;
// a 2-entry queue parts front and back; reset: synchronous, active low, then a clearing pass
// sweeps all WINDOW_BLOCKS*512 page entries (1024 by default) while input stays stalled
// top level: apb register block, front end, back end; depends on dpfm_pkg, dpfm_front, dpfm_back
module demand_page_fault_mapper_core import dpfm_pkg::*; #(
    parameter int WINDOW_BLOCKS = DEF_WINDOW_BLOCKS,
    parameter int POOL_FRAMES   = DEF_POOL_FRAMES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VA_W-1:0]       i_fault_address,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_handled,
    output logic [DESC_W-1:0]     o_descriptor,
    output logic [VPN_W-1:0]      o_tlb_page,
    output logic [CNT_W-1:0]      o_mapped_total,
    output logic [CNT_W-1:0]      o_oom_total
);

    localparam int WINDOW_PAGES = WINDOW_BLOCKS * ENTRIES_PER_TABLE;
    localparam int IDX_W = $clog2(WINDOW_PAGES);
    localparam int ITEM_W = 1 + VPN_W + IDX_W;

    logic [VA_W-1:0]   r_window_base;
    logic [PA_W-1:0]   r_pool_base;
    logic              cfg_wr;
    logic              q_valid;
    logic [ITEM_W-1:0] q_item;
    logic              q_pop;
    logic              clearing;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_base <= WINDOW_BASE_RST;
            r_pool_base   <= '0;
        end else if (cfg_wr) begin
            case (paddr[3])
                REG_WINDOW_BASE: r_window_base <= pwdata[VA_W-1:0];
                REG_POOL_BASE:   r_pool_base   <= pwdata[PA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_WINDOW_BASE: prdata = APB_DATA_W'(r_window_base);
            REG_POOL_BASE:   prdata = APB_DATA_W'(r_pool_base);
            default:         prdata = '0;
        endcase
    end

    dpfm_front #(
        .WINDOW_BLOCKS (WINDOW_BLOCKS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_fault_address (i_fault_address),
        .i_window_base   (r_window_base),
        .i_hold          (clearing),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    dpfm_back #(
        .WINDOW_BLOCKS (WINDOW_BLOCKS),
        .POOL_FRAMES   (POOL_FRAMES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_clearing     (clearing),
        .i_pool_base    (r_pool_base),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_handled      (o_handled),
        .o_descriptor   (o_descriptor),
        .o_tlb_page     (o_tlb_page),
        .o_mapped_total (o_mapped_total),
        .o_oom_total    (o_oom_total)
    );

endmodule

/* rtl/dpfm_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module dpfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dpfm_front.sv */
// front end: accepts faulting addresses, checks the demand window, queues items
// depends on dpfm_pkg
module dpfm_front import dpfm_pkg::*; #(
    parameter int WINDOW_BLOCKS = DEF_WINDOW_BLOCKS,
    localparam int WINDOW_PAGES = WINDOW_BLOCKS * ENTRIES_PER_TABLE,
    localparam int IDX_W = $clog2(WINDOW_PAGES),
    localparam int ITEM_W = 1 + VPN_W + IDX_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [VA_W-1:0]   i_fault_address,
    input  logic [VA_W-1:0]   i_window_base,
    input  logic              i_hold,
    output logic              o_q_valid,
    output logic [ITEM_W-1:0] o_q_item,
    input  logic              i_q_pop
);

    localparam logic [VA_W-1:0] WIN_BYTES = VA_W'(WINDOW_BLOCKS) << BLOCK_SHIFT;

    logic [ITEM_W-1:0] r_slot [2];
    logic              r_wr_ptr, n_wr_ptr;
    logic              r_rd_ptr, n_rd_ptr;
    logic [1:0]        r_count, n_count;

    logic [VA_W:0]     diff;
    logic              outside;
    logic              push;
    logic [ITEM_W-1:0] item;

    // borrow out of the subtract means the address is below the base
    assign diff    = {1'b0, i_fault_address} - {1'b0, i_window_base};
    assign outside = diff[VA_W] || (diff[VA_W-1:0] >= WIN_BYTES);
    assign item    = {outside, i_fault_address[VA_W-1:PAGE_SHIFT],
                      diff[PAGE_SHIFT +: IDX_W]};

    assign o_in_stall = (r_count == 2'd2) || i_hold;
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push;
        n_rd_ptr = r_rd_ptr ^ i_q_pop;
        n_count  = r_count + 2'(push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= item;
        end
    end

endmodule

/* rtl/dpfm_back.sv */
// back end: page entry lookup and update, frame pool, counters, result register
// depends on dpfm_pkg and dpfm_ram
module dpfm_back import dpfm_pkg::*; #(
    parameter int WINDOW_BLOCKS = DEF_WINDOW_BLOCKS,
    parameter int POOL_FRAMES   = DEF_POOL_FRAMES,
    localparam int WINDOW_PAGES = WINDOW_BLOCKS * ENTRIES_PER_TABLE,
    localparam int IDX_W = $clog2(WINDOW_PAGES),
    localparam int ITEM_W = 1 + VPN_W + IDX_W,
    localparam int FR_W = $clog2(POOL_FRAMES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  logic [ITEM_W-1:0]   i_q_item,
    output logic                o_q_pop,
    output logic                o_clearing,
    input  logic [PA_W-1:0]     i_pool_base,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_handled,
    output logic [DESC_W-1:0]   o_descriptor,
    output logic [VPN_W-1:0]    o_tlb_page,
    output logic [CNT_W-1:0]    o_mapped_total,
    output logic [CNT_W-1:0]    o_oom_total
);

    localparam int ENT_W = 1 + FR_W;

    t_back_state         r_state, n_state;
    logic [IDX_W-1:0]    r_clr_idx, n_clr_idx;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [VPN_W-1:0]    r_vpn, n_vpn;
    logic [FR_W-1:0]     r_next_frame, n_next_frame;
    logic [CNT_W-1:0]    r_mapped, n_mapped;
    logic [CNT_W-1:0]    r_refused, n_refused;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_handled, n_handled;
    logic [DESC_W-1:0]   r_desc, n_desc;
    logic [VPN_W-1:0]    r_tlb, n_tlb;

    logic                q_outside;
    logic [VPN_W-1:0]    q_vpn;
    logic [IDX_W-1:0]    q_idx;
    logic                out_free;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic [ENT_W-1:0]    ram_rdata;
    logic [PPN_W-1:0]    ppn;

    assign q_outside = i_q_item[ITEM_W-1];
    assign q_vpn     = i_q_item[IDX_W +: VPN_W];
    assign q_idx     = i_q_item[IDX_W-1:0];
    assign out_free  = !r_out_valid || !i_out_stall;
    // low 12 bits of the pool base drop out, the frame address wraps at 40 bits
    assign ppn       = i_pool_base[PA_W-1:PAGE_SHIFT] + PPN_W'(r_next_frame);

    dpfm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW_PAGES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (q_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_idx        = r_idx;
        n_vpn        = r_vpn;
        n_next_frame = r_next_frame;
        n_mapped     = r_mapped;
        n_refused    = r_refused;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_handled    = r_handled;
        n_desc       = r_desc;
        n_tlb        = r_tlb;
        o_q_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = {1'b1, r_next_frame};
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(WINDOW_PAGES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // entry read goes out here, its data is back in the next cycle
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    n_idx   = q_idx;
                    n_vpn   = q_vpn;
                    if (q_outside) begin
                        n_out_valid = 1'b1;
                        n_status    = STATUS_OUTSIDE;
                        n_handled   = 1'b0;
                        n_desc      = '0;
                        n_tlb       = '0;
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_desc      = '0;
                n_tlb       = '0;
                if (ram_rdata[ENT_W-1]) begin
                    n_status  = STATUS_PRESENT;
                    n_handled = 1'b1;
                end else if (r_next_frame == FR_W'(POOL_FRAMES)) begin
                    n_status  = STATUS_NOMEM;
                    n_handled = 1'b0;
                    n_refused = r_refused + 1'b1;
                end else begin
                    ram_we       = 1'b1;
                    n_status     = STATUS_MAPPED;
                    n_handled    = 1'b1;
                    n_desc       = {DESC_UPPER, ppn, DESC_LOWER};
                    n_tlb        = r_vpn;
                    n_next_frame = r_next_frame + 1'b1;
                    n_mapped     = r_mapped + 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_idx    <= '0;
            r_next_frame <= '0;
            r_mapped     <= '0;
            r_refused    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_idx    <= n_clr_idx;
            r_next_frame <= n_next_frame;
            r_mapped     <= n_mapped;
            r_refused    <= n_refused;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_vpn     <= n_vpn;
        r_status  <= n_status;
        r_handled <= n_handled;
        r_desc    <= n_desc;
        r_tlb     <= n_tlb;
    end

    // counters only move together with a result load, so they match the held result
    assign o_clearing     = (r_state == ST_CLEAR);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_handled      = r_handled;
    assign o_descriptor   = r_desc;
    assign o_tlb_page     = r_tlb;
    assign o_mapped_total = r_mapped;
    assign o_oom_total    = r_refused;

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_frame <= FR_W'(POOL_FRAMES))
        else $error("frame pointer past pool end");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_q_pop)
        else $error("item taken during clearing pass");

    a_map_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_next_frame != $past(r_next_frame)))
            |-> (r_mapped == $past(r_mapped) + 32'd1))
        else $error("mapped count out of step with frame pool");

    a_write_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state != ST_CLEAR)) |-> ((r_state == ST_LOOK) && !ram_rdata[ENT_W-1]))
        else $error("page entry written without a miss");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |-> !r_out_valid || !$past(r_out_valid && i_out_stall))
        else $error("lookup finished over an untaken result");

endmodule

/* sim/tb_demand_page_fault_mapper_core.sv */
`timescale 1ns / 100ps
// self-checking testbench for demand_page_fault_mapper_core: directed and random faults
// under several window and pool setups, with stalls on both sides; depends on dpfm_pkg and the core
module tb_demand_page_fault_mapper_core;
    import dpfm_pkg::*;

    localparam int          WIN_PAGES      = DEF_WINDOW_BLOCKS * ENTRIES_PER_TABLE;
    localparam int unsigned WIN_BYTES      = WIN_PAGES << PAGE_SHIFT;
    localparam int          POOL_SIZE      = DEF_POOL_FRAMES;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 4;

    localparam logic [VA_W-1:0] VA_MAX              = '1;
    localparam logic [VA_W-1:0] WINDOW_BASE_DEFAULT = 39'h00_8000_0000;
    localparam logic [PA_W-1:0] POOL_BASE_MAX       = 40'hFF_FFFF_F000;

    // fixed descriptor bits of a normal, inner shareable, read-write, no-execute page
    localparam logic [DESC_W-1:0] PAGE_TYPE       = 55'h3;
    localparam logic [DESC_W-1:0] ATTR_INDEX_1    = 55'h4;
    localparam logic [DESC_W-1:0] INNER_SHAREABLE = 55'h300;
    localparam logic [DESC_W-1:0] ACCESS_FLAG     = 55'h400;
    localparam logic [DESC_W-1:0] PRIV_NO_EXEC    = 55'h1 << 53;
    localparam logic [DESC_W-1:0] USER_NO_EXEC    = 55'h1 << 54;
    localparam logic [DESC_W-1:0] DESC_FLAGS      = PAGE_TYPE | ATTR_INDEX_1 | INNER_SHAREABLE
                                                  | ACCESS_FLAG | PRIV_NO_EXEC | USER_NO_EXEC;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                handled;
        logic [DESC_W-1:0]   descriptor;
        logic [VPN_W-1:0]    tlb_page;
        logic [CNT_W-1:0]    mapped_total;
        logic [CNT_W-1:0]    oom_total;
    } t_fault_result;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [APB_DATA_W-1:0] pwdata          = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [VA_W-1:0]       i_fault_address = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_handled;
    logic [DESC_W-1:0]     o_descriptor;
    logic [VPN_W-1:0]      o_tlb_page;
    logic [CNT_W-1:0]      o_mapped_total;
    logic [CNT_W-1:0]      o_oom_total;

    // mirror of the mapper state
    logic [VA_W-1:0]  win_base      = WINDOW_BASE_DEFAULT;
    logic [PA_W-1:0]  pool_addr     = '0;
    bit               page_present [WIN_PAGES];
    int unsigned      frames_used   = 0;
    logic [CNT_W-1:0] mapped_count  = '0;
    logic [CNT_W-1:0] refused_count = '0;

    t_fault_result pending_results[$];
    int unsigned   faults_sent     = 0;
    int unsigned   results_checked = 0;
    int unsigned   errors          = 0;
    int unsigned   stuck_cycles    = 0;
    int unsigned   status_seen [4];
    bit            idle_on         = 1'b1;
    bit            hold_req        = 1'b0;

    demand_page_fault_mapper_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_fault_address (i_fault_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_handled       (o_handled),
        .o_descriptor    (o_descriptor),
        .o_tlb_page      (o_tlb_page),
        .o_mapped_total  (o_mapped_total),
        .o_oom_total     (o_oom_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // expected result of one fault; updates the mirrored entries, pool and counters
    function automatic t_fault_result resolve_fault(input logic [VA_W-1:0] va);
        t_fault_result   r;
        logic [63:0]     offset;
        logic [PA_W-1:0] frame_step;
        logic [PA_W-1:0] frame_pa;
        int unsigned     slot;
        r.status     = STATUS_OUTSIDE;
        r.handled    = 1'b0;
        r.descriptor = '0;
        r.tlb_page   = '0;
        offset = 64'(va) - 64'(win_base);
        if (va >= win_base && offset < 64'(WIN_BYTES)) begin
            slot = offset[31:0] >> PAGE_SHIFT;
            if (page_present[slot]) begin
                r.status  = STATUS_PRESENT;
                r.handled = 1'b1;
            end else if (frames_used >= POOL_SIZE) begin
                refused_count++;
                r.status = STATUS_NOMEM;
            end else begin
                frame_step = PA_W'(frames_used);
                frame_pa   = pool_addr + (frame_step << PAGE_SHIFT);
                page_present[slot] = 1'b1;
                frames_used++;
                mapped_count++;
                r.status     = STATUS_MAPPED;
                r.handled    = 1'b1;
                r.descriptor = DESC_FLAGS;
                r.descriptor[PA_W-1:PAGE_SHIFT] = frame_pa[PA_W-1:PAGE_SHIFT];
                r.tlb_page   = va[VA_W-1:PAGE_SHIFT];
            end
        end
        r.mapped_total = mapped_count;
        r.oom_total    = refused_count;
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // prediction is pushed before the result check so both happen in one place per edge
    always @(posedge i_clk) begin : monitor
        t_fault_result want;
        bit            moved;
        moved = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pending_results.push_back(resolve_fault(i_fault_address));
            moved = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            moved = 1'b1;
            results_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no fault pending, expected none, got status %0d",
                         $time, o_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                compare_field("status", 64'(want.status), 64'(o_status));
                compare_field("handled", 64'(want.handled), 64'(o_handled));
                compare_field("descriptor", 64'(want.descriptor), 64'(o_descriptor));
                compare_field("tlb_page", 64'(want.tlb_page), 64'(o_tlb_page));
                compare_field("mapped_total", 64'(want.mapped_total), 64'(o_mapped_total));
                compare_field("oom_total", 64'(want.oom_total), 64'(o_oom_total));
            end
        end
        if (psel && penable && pwrite && pready)
            moved = 1'b1;
        stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end

    initial begin : watchdog
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("%0t ns: nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_demand_page_fault_mapper_core: FAIL");
        $finish;
    end

    // result side: random stall bursts, or one long hold-off when asked
    initial begin : receiver
        int unsigned burst;
        int unsigned hold_count;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 14);
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // valid stays high between back-to-back items and drops only for a gap or in wait_results
    task automatic send_fault(input logic [VA_W-1:0] va);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_fault_address <= va;
        do @(posedge i_clk); while (o_in_stall);
        faults_sent++;
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (results_checked < faults_sent)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_WINDOW_BASE)
            win_base = value[VA_W-1:0];
        else
            pool_addr = value[PA_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic apply_setup(input logic [63:0] base, input logic [63:0] pool);
        wait_results();
        write_reg(REG_WINDOW_BASE, base);
        write_reg(REG_POOL_BASE, pool);
    endtask

    // mostly inside the window, some right at its edges, the rest anywhere
    function automatic logic [VA_W-1:0] pick_address();
        logic [63:0]     target;
        logic [VA_W-1:0] noise;
        int unsigned     pick;
        noise = VA_W'({$urandom, $urandom});
        pick  = $urandom_range(0, 99);
        if (pick < 72) begin
            target = 64'(win_base) + 64'($urandom_range(0, WIN_BYTES - 1));
        end else if (pick < 84) begin
            case ($urandom_range(0, 3))
                0:       target = 64'(win_base) - 64'd1;
                1:       target = 64'(win_base);
                2:       target = 64'(win_base) + 64'(WIN_BYTES) - 64'd1;
                default: target = 64'(win_base) + 64'(WIN_BYTES);
            endcase
        end else begin
            target = 64'(noise);
        end
        // window edge past the top of the address space, or below zero
        if (target > 64'(VA_MAX))
            target = 64'(noise);
        return target[VA_W-1:0];
    endfunction

    task automatic test_window_edges();
        send_fault(39'h00_8000_0000);
        send_fault(39'h00_8000_0ABC);
        send_fault(39'h00_7FFF_FFFF);
        send_fault(39'h00_803F_FFFF);
        send_fault(39'h00_8040_0000);
        send_fault('0);
        send_fault(VA_MAX);
    endtask

    // frames past the pool base wrap around the physical address space
    task automatic test_unaligned_window();
        apply_setup(64'h123, 64'(POOL_BASE_MAX));
        send_fault(39'h122);
        send_fault(39'h123);
        send_fault(39'h1123);
        send_fault(39'h3122);
        send_fault(39'h40_0122);
        send_fault(39'h40_0123);
    endtask

    task automatic test_window_extremes();
        apply_setup({25'h155_5555, VA_MAX}, {24'hA5A5A5, 40'h12_3456_7ABC});
        send_fault(VA_MAX);
        send_fault(VA_MAX - 39'd1);
        apply_setup(64'(VA_MAX - 39'h4FF8), 64'h12_3456_7ABC);
        send_fault(VA_MAX);
        apply_setup(64'd0, 64'd0);
        send_fault('0);
        send_fault(39'h3F_FFFF);
        send_fault(39'h40_0000);
        send_fault(39'h5FFF);
    endtask

    task automatic test_random_setups();
        logic [63:0] base;
        logic [63:0] pool;
        for (int s = 0; s < 4; s++) begin
            base = {$urandom, $urandom};
            pool = {$urandom, $urandom};
            case (s)
                0: begin
                    base = 64'(WINDOW_BASE_DEFAULT);
                    pool = '0;
                end
                1: begin
                    base[21:0] = '0;
                    pool[11:0] = '0;
                end
                2: ;
                default: begin
                    base = 64'(VA_MAX) - 64'($urandom_range(0, WIN_BYTES));
                    pool = 64'(POOL_BASE_MAX) - 64'($urandom_range(0, 63) << PAGE_SHIFT);
                end
            endcase
            if (pool[PA_W-1:0] > POOL_BASE_MAX)
                pool[11:0] = '0;
            apply_setup(base, pool);
            repeat (50) send_fault(pick_address());
        end
    endtask

    // results held back long enough that the block has to stall its input
    task automatic test_output_pressure();
        bit keep_idle;
        keep_idle = idle_on;
        idle_on   = 1'b0;
        hold_req  = 1'b1;
        repeat (24) send_fault(pick_address());
        idle_on = keep_idle;
    endtask

    // walk the window in a scrambled page order past the point where the pool runs dry, until 12 refusals in all
    task automatic test_pool_exhaustion();
        logic [63:0] base;
        int unsigned stride;
        int unsigned first;
        int unsigned page;
        base = {$urandom, $urandom};
        base[21:0] = '0;
        apply_setup(base, {$urandom, $urandom} & 64'hFF_FFFF_F000);
        stride = 2 * $urandom_range(0, WIN_PAGES / 2 - 1) + 1;
        first  = $urandom_range(0, WIN_PAGES - 1);
        for (int k = 0; k < WIN_PAGES && refused_count < 12; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_fault(pick_address());
            page = (first + k * stride) % WIN_PAGES;
            send_fault(win_base + VA_W'(page << PAGE_SHIFT)
                       + VA_W'($urandom_range(0, 4095)));
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        apply_setup({$urandom, $urandom}, 64'(POOL_BASE_MAX));
        repeat (60) send_fault(pick_address());
        apply_setup(64'(WINDOW_BASE_DEFAULT), 64'd0);
        repeat (60) send_fault(pick_address());
    endtask

    initial begin : main
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_window_edges();
        test_unaligned_window();
        test_window_extremes();
        test_random_setups();
        test_output_pressure();
        test_pool_exhaustion();
        test_steady_stream();
        wait_results();
        $display("%0d faults: %0d mapped, %0d already present, %0d outside, %0d refused",
                 faults_sent, status_seen[STATUS_MAPPED], status_seen[STATUS_PRESENT],
                 status_seen[STATUS_OUTSIDE], status_seen[STATUS_NOMEM]);
        $display("%0d results checked over several window/pool setups, %0d mismatches",
                 results_checked, errors);
        if (errors == 0)
            $display("tb_demand_page_fault_mapper_core: PASS");
        else
            $display("tb_demand_page_fault_mapper_core: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dpfm_pkg.sv
rtl/dpfm_ram.sv
rtl/dpfm_front.sv
rtl/dpfm_back.sv
rtl/demand_page_fault_mapper_core.sv
sim/tb_demand_page_fault_mapper_core.sv
